// File: rtl/smrh_pkg.sv
// Package of shared types, constants and a rotate helper function for the multiply-rotate hash.
`timescale 1ns / 1ps

package smrh_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 3;

	localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd4;

	localparam logic [WORD_W-1:0] PRIME1 = 32'd2654435761;
	localparam logic [WORD_W-1:0] PRIME2 = 32'd2246822519;
	localparam logic [WORD_W-1:0] PRIME3 = 32'd3266489917;
	localparam logic [WORD_W-1:0] PRIME4 = 32'd668265263;
	localparam logic [WORD_W-1:0] PRIME5 = 32'h165667b1;

	localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_W_ADD,
		S_W_ROT,
		S_W_ACC,
		S_W_MUL,
		S_B_ADD,
		S_B_MUL,
		S_F_LEN,
		S_F_X15,
		S_F_M2,
		S_F_X13,
		S_F_M3,
		S_FINISH
	} state_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_WADD,
		OP_WROT,
		OP_ACC,
		OP_MULP1,
		OP_BADD,
		OP_FLEN,
		OP_X15,
		OP_MULP2,
		OP_X13,
		OP_MULP3,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic bytes_left;
	} status_t;

	function automatic logic [WORD_W-1:0] rotl17(input logic [WORD_W-1:0] v);
		rotl17 = {v[WORD_W-18:0], v[WORD_W-1:WORD_W-17]};
	endfunction

endpackage

// File: rtl/smrh_channels.sv
// Channel interfaces: message input, digest output and seed configuration.
`timescale 1ns / 1ps

interface smrh_msg_if;
	logic                            valid;
	logic                            ready;
	logic [smrh_pkg::WORD_W-1:0]     data_word;
	logic [smrh_pkg::COUNT_W-1:0]    byte_count;
	logic                            last;

	modport source (output valid, data_word, byte_count, last, input ready);
	modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface smrh_digest_if;
	logic                        valid;
	logic                        ready;
	logic [smrh_pkg::WORD_W-1:0] hash_value;
	logic                        bad_framing;

	modport source (output valid, hash_value, bad_framing, input ready);
	modport sink (input valid, hash_value, bad_framing, output ready);
endinterface

interface smrh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [smrh_pkg::WORD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/smrh_dp.sv
// Datapath of the hash: state registers, one shared multiplier, adders and result register.
`timescale 1ns / 1ps

module smrh_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smrh_pkg::cmd_t                cmd,
	output smrh_pkg::status_t             status,
	input  logic [smrh_pkg::WORD_W-1:0]   data_word,
	input  logic [smrh_pkg::COUNT_W-1:0]  byte_count,
	input  logic                          last,
	input  logic                          cfg_valid,
	input  logic [smrh_pkg::WORD_W-1:0]   cfg_data,
	output logic [smrh_pkg::WORD_W-1:0]   hash_value,
	output logic                          bad_framing
);

	logic [smrh_pkg::WORD_W-1:0]  seed_q;
	logic [smrh_pkg::WORD_W-1:0]  hash_q;
	logic [smrh_pkg::WORD_W-1:0]  idx_q;
	logic [smrh_pkg::WORD_W-1:0]  total_q;
	logic                         words_q;
	logic [smrh_pkg::WORD_W-1:0]  prod_q;
	logic [smrh_pkg::WORD_W-1:0]  word_q;
	logic [smrh_pkg::COUNT_W-1:0] count_q;
	logic [smrh_pkg::COUNT_W-1:0] pos_q;
	logic                         last_q;
	logic [smrh_pkg::WORD_W-1:0]  hash_out_q;
	logic                         flag_out_q;

	logic [smrh_pkg::WORD_W-1:0]  mul_a;
	logic [smrh_pkg::WORD_W-1:0]  mul_b;
	logic [smrh_pkg::WORD_W-1:0]  prod;
	logic [7:0]                   tail_byte;
	logic [smrh_pkg::COUNT_W-1:0] count_sat;
	logic [smrh_pkg::WORD_W-1:0]  hash_d;

	// The rotate feeds the multiplier only in the word step; otherwise the hash itself.
	always_comb begin
		mul_a = (cmd.op == smrh_pkg::OP_WROT) ? smrh_pkg::rotl17(hash_q) : hash_q;
		case (cmd.op)
			smrh_pkg::OP_WROT:  mul_b = smrh_pkg::PRIME4;
			smrh_pkg::OP_MULP2: mul_b = smrh_pkg::PRIME2;
			smrh_pkg::OP_MULP3: mul_b = smrh_pkg::PRIME3;
			default:            mul_b = smrh_pkg::PRIME1;
		endcase
	end

	assign prod      = mul_a * mul_b;
	assign tail_byte = word_q[8*pos_q[1:0] +: 8];
	assign count_sat = (byte_count > smrh_pkg::MAX_BYTES) ? smrh_pkg::MAX_BYTES : byte_count;

	always_comb begin
		case (cmd.op)
			smrh_pkg::OP_WADD:   hash_d = hash_q + word_q + idx_q;
			smrh_pkg::OP_ACC:    hash_d = hash_q + prod_q;
			smrh_pkg::OP_MULP1,
			smrh_pkg::OP_MULP2,
			smrh_pkg::OP_MULP3:  hash_d = prod;
			smrh_pkg::OP_BADD:   hash_d = hash_q + {24'd0, tail_byte} + idx_q;
			smrh_pkg::OP_FLEN:   hash_d = hash_q + total_q
				+ {{(smrh_pkg::WORD_W-smrh_pkg::COUNT_W){1'b0}}, count_q};
			smrh_pkg::OP_X15:    hash_d = hash_q ^ (hash_q >> 15);
			smrh_pkg::OP_X13:    hash_d = hash_q ^ (hash_q >> 13);
			smrh_pkg::OP_FINISH: hash_d = smrh_pkg::PRIME5;
			default:             hash_d = hash_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			hash_q  <= smrh_pkg::PRIME5;
			idx_q   <= smrh_pkg::PRIME1;
			total_q <= '0;
			words_q <= 1'b0;
		end else begin
			hash_q <= hash_d;
			if (cfg_valid) begin
				seed_q <= cfg_data;
				if (!words_q) begin
					idx_q <= cfg_data + smrh_pkg::PRIME1;
				end
			end else if (cmd.op == smrh_pkg::OP_WADD || cmd.op == smrh_pkg::OP_BADD) begin
				idx_q <= idx_q + 32'd1;
			end else if (cmd.op == smrh_pkg::OP_FINISH) begin
				idx_q <= seed_q + smrh_pkg::PRIME1;
			end
			if (cmd.op == smrh_pkg::OP_WADD) begin
				total_q <= total_q + smrh_pkg::WORD_BYTES;
				words_q <= 1'b1;
			end else if (cmd.op == smrh_pkg::OP_FINISH) begin
				total_q <= '0;
				words_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.op == smrh_pkg::OP_WROT) begin
			prod_q <= prod;
		end
		if (cmd.op == smrh_pkg::OP_LOAD) begin
			word_q  <= data_word;
			count_q <= count_sat;
			last_q  <= last;
			pos_q   <= '0;
		end else if (cmd.op == smrh_pkg::OP_BADD) begin
			pos_q <= pos_q + 3'd1;
		end
		if (cmd.op == smrh_pkg::OP_FINISH) begin
			hash_out_q <= hash_q ^ (hash_q >> 16);
			flag_out_q <= (count_q == '0) && words_q;
		end
	end

	assign status.last       = last_q;
	assign status.bytes_left = (pos_q != count_q);
	assign hash_value        = hash_out_q;
	assign bad_framing       = flag_out_q;

endmodule

// File: rtl/smrh_ctrl.sv
// Controller state machine: sequences the datapath operations and owns the handshakes.
`timescale 1ns / 1ps

module smrh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	output logic                digest_valid,
	input  logic                digest_ready,
	input  smrh_pkg::status_t   status,
	output smrh_pkg::cmd_t      cmd
);

	smrh_pkg::state_t state_q;
	smrh_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || digest_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smrh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == smrh_pkg::OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (digest_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = smrh_pkg::OP_NONE;
		case (state_q)
			smrh_pkg::S_IDLE: begin
				if (msg_valid) begin
					cmd.op  = smrh_pkg::OP_LOAD;
					state_d = smrh_pkg::S_DISPATCH;
				end
			end
			smrh_pkg::S_DISPATCH: begin
				if (!status.last) begin
					state_d = smrh_pkg::S_W_ADD;
				end else if (status.bytes_left) begin
					state_d = smrh_pkg::S_B_ADD;
				end else begin
					state_d = smrh_pkg::S_F_LEN;
				end
			end
			smrh_pkg::S_W_ADD: begin
				cmd.op  = smrh_pkg::OP_WADD;
				state_d = smrh_pkg::S_W_ROT;
			end
			smrh_pkg::S_W_ROT: begin
				cmd.op  = smrh_pkg::OP_WROT;
				state_d = smrh_pkg::S_W_ACC;
			end
			smrh_pkg::S_W_ACC: begin
				cmd.op  = smrh_pkg::OP_ACC;
				state_d = smrh_pkg::S_W_MUL;
			end
			smrh_pkg::S_W_MUL: begin
				cmd.op  = smrh_pkg::OP_MULP1;
				state_d = smrh_pkg::S_IDLE;
			end
			smrh_pkg::S_B_ADD: begin
				cmd.op  = smrh_pkg::OP_BADD;
				state_d = smrh_pkg::S_B_MUL;
			end
			smrh_pkg::S_B_MUL: begin
				cmd.op  = smrh_pkg::OP_MULP1;
				state_d = status.bytes_left ? smrh_pkg::S_B_ADD : smrh_pkg::S_F_LEN;
			end
			smrh_pkg::S_F_LEN: begin
				cmd.op  = smrh_pkg::OP_FLEN;
				state_d = smrh_pkg::S_F_X15;
			end
			smrh_pkg::S_F_X15: begin
				cmd.op  = smrh_pkg::OP_X15;
				state_d = smrh_pkg::S_F_M2;
			end
			smrh_pkg::S_F_M2: begin
				cmd.op  = smrh_pkg::OP_MULP2;
				state_d = smrh_pkg::S_F_X13;
			end
			smrh_pkg::S_F_X13: begin
				cmd.op  = smrh_pkg::OP_X13;
				state_d = smrh_pkg::S_F_M3;
			end
			smrh_pkg::S_F_M3: begin
				cmd.op  = smrh_pkg::OP_MULP3;
				state_d = smrh_pkg::S_FINISH;
			end
			smrh_pkg::S_FINISH: begin
				if (out_free) begin
					cmd.op  = smrh_pkg::OP_FINISH;
					state_d = smrh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smrh_pkg::S_IDLE;
			end
		endcase
	end

	assign msg_ready    = (state_q == smrh_pkg::S_IDLE);
	assign digest_valid = out_valid_q;

`ifndef SYNTH
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && msg_ready) |=> state_q == smrh_pkg::S_DISPATCH)
		else $error("accepted transaction did not reach dispatch");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smrh_pkg::S_FINISH && out_free) |=> digest_valid)
		else $error("finished hash not presented on the digest channel");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smrh_pkg::S_FINISH && !out_free) |=> state_q == smrh_pkg::S_FINISH)
		else $error("result overwritten while digest still pending");

	a_tail_to_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smrh_pkg::S_B_MUL && !status.bytes_left) |=> state_q == smrh_pkg::S_F_LEN)
		else $error("byte loop did not end in the length step");
`endif

endmodule

// File: rtl/small_multiply_rotate_hash32.sv
// Top level of the 32-bit multiply-rotate message hash.
`timescale 1ns / 1ps

// This block hashes a byte message, delivered as a stream of little-endian 32-bit
// words on the msg channel, into one 32-bit digest on the digest channel. Every
// transaction with last low is a full word of four bytes; the transaction with
// last high carries the zero to four tail bytes (a byte_count above four counts as
// four) and produces exactly one digest, after which the hash restarts for the next
// message. bad_framing is set when a last transaction with no bytes follows earlier
// words; the digest is still formed over those words. The seed is written through
// the cfg channel, which is always ready, and must only be written while the block
// is idle; it takes effect at once if no word of the current message has yet been
// taken, otherwise at the start of the next message. All work goes through a single
// shared 32-bit multiplier with a registered product, sequenced by a controller one
// operation per cycle, except that finish waits for the previous digest to be taken.
// A word transaction passes through accept, dispatch and four operations for add,
// rotate-multiply, accumulate and multiply; a last one through accept, dispatch, an
// add and a multiply per tail byte, and finalization. A finished digest sits in an
// output register, so the next message may be accepted while it waits.

module small_multiply_rotate_hash32 (
	input  logic          clk,
	input  logic          arst_n,
	smrh_msg_if.sink      msg,
	smrh_digest_if.source digest,
	smrh_cfg_if.sink      cfg
);

	smrh_pkg::cmd_t    cmd;
	smrh_pkg::status_t status;

	// The seed register is written in any cycle; no back-pressure is needed.
	assign cfg.ready = 1'b1;

	smrh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.msg_ready    (msg.ready),
		.digest_valid (digest.valid),
		.digest_ready (digest.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds the running hash, step index, byte total and the
	// result register that feeds the digest payload.
	smrh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_word   (msg.data_word),
		.byte_count  (msg.byte_count),
		.last        (msg.last),
		.cfg_valid   (cfg.valid),
		.cfg_data    (cfg.data),
		.hash_value  (digest.hash_value),
		.bad_framing (digest.bad_framing)
	);

endmodule

// File: tb/sv/small_multiply_rotate_hash32_test.sv
// Self-checking testbench for the 32-bit multiply-rotate message hash.
`timescale 1ns / 1ps

// The bench drives messages into the msg channel from a queue of pending transactions
// and takes digests from the digest channel. Both sides idle at random. An
// independent model of the hash is updated at every accepted msg transaction. It
// queues the digest that each last transaction should produce. The monitor compares
// every digest taken from the block, field by field, with the oldest queued digest.
//
// Seed writes go through the cfg channel only once the block has drained. Some
// phases end in the middle of a message, so that a write with words already taken
// is tested, where the seed is deferred, as well as a write between messages, where
// it takes effect at once.

module small_multiply_rotate_hash32_test;

	// Hash constants, kept here independently of the design.
	localparam logic [31:0] HASH_P1 = 32'd2654435761;
	localparam logic [31:0] HASH_P2 = 32'd2246822519;
	localparam logic [31:0] HASH_P3 = 32'd3266489917;
	localparam logic [31:0] HASH_P4 = 32'd668265263;
	localparam logic [31:0] HASH_P5 = 32'h165667b1;

	localparam int RANDOM_ITEMS = 1950;
	// Cycles that a word transaction may still be in flight once the channels are quiet.
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [smrh_pkg::WORD_W-1:0]  data_word;
		logic [smrh_pkg::COUNT_W-1:0] byte_count;
		logic                         last;
	} msg_item_t;

	typedef struct packed {
		logic [smrh_pkg::WORD_W-1:0] hash_value;
		logic                        bad_framing;
	} digest_t;

	logic clk;
	logic arst_n;

	smrh_msg_if    msg_ch ();
	smrh_digest_if dig_ch ();
	smrh_cfg_if    cfg_ch ();

	small_multiply_rotate_hash32 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch),
		.cfg    (cfg_ch)
	);

	// Transactions waiting to be sent, and digests that the model says must come.
	msg_item_t pending_items[$];
	digest_t   expected_digests[$];

	// The model's copy of the seed and the hash state.
	logic [31:0] hash_seed;
	logic [31:0] acc_hash;
	logic [31:0] step_idx;
	logic [31:0] len_total;
	logic        words_taken;

	int error_count;
	int cycle_count;
	int queued_count;
	int drv_wait;
	int stall_wait;
	bit drv_calm;
	bit mon_calm;
	digest_t mon_want;

	// Free-running clock with an 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every mismatch goes through here, so that one line is printed and it is counted.
	task automatic report_mismatch(input string text);
		$display("ERROR at cycle %0d: %s", cycle_count, text);
		error_count++;
	endtask

	// Most gaps are short, a few are long. In a calm phase there are none at all.
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Random data with the all-zero and all-one words mixed in now and then.
	function automatic logic [31:0] random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 32'h0000_0000;
		else if (r < 6)
			return 32'hffff_ffff;
		else
			return $urandom;
	endfunction

	// A new message starts from the fixed starting hash and an index of seed plus the first prime.
	task automatic restart_hash();
		acc_hash    = HASH_P5;
		step_idx    = hash_seed + HASH_P1;
		len_total   = 32'd0;
		words_taken = 1'b0;
	endtask

	// Advance the model by one accepted msg transaction. A last transaction queues one digest.
	task automatic absorb_item(input logic [31:0] word, input logic [2:0] count,
			input logic is_last);
		logic [31:0] h;
		logic [2:0]  n;
		digest_t     d;
		int          k;
		h = acc_hash;
		if (!is_last) begin
			// Full word: add it with the index, fold in the rotated value, then scramble.
			h = h + word + step_idx;
			h = h + {h[14:0], h[31:15]} * HASH_P4;
			h = h * HASH_P1;
			acc_hash    = h;
			step_idx    = step_idx + 32'd1;
			len_total   = len_total + 32'd4;
			words_taken = 1'b1;
		end else begin
			// Tail counts above four are treated as four.
			n = (count > 3'd4) ? 3'd4 : count;
			// An empty tail after words is a framing error, though the digest is still formed.
			d.bad_framing = (n == 3'd0) && words_taken;
			for (k = 0; k < n; k++) begin
				h = h + word[8*k +: 8] + step_idx;
				h = h * HASH_P1;
				step_idx = step_idx + 32'd1;
			end
			h = h + len_total + n;
			h = h ^ (h >> 15);
			h = h * HASH_P2;
			h = h ^ (h >> 13);
			h = h * HASH_P3;
			h = h ^ (h >> 16);
			d.hash_value = h;
			expected_digests = {expected_digests, d};
			restart_hash();
		end
	endtask

	task automatic queue_item(input logic [31:0] word, input logic [2:0] count,
			input logic is_last);
		msg_item_t it;
		it.data_word  = word;
		it.byte_count = count;
		it.last       = is_last;
		pending_items = {pending_items, it};
		queued_count++;
	endtask

	// Wait until every transaction has been sent and every digest taken, then let a word
	// that is still being processed finish before anything else happens.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || msg_ch.valid || expected_digests.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One transaction on the cfg channel. The model takes the seed at the same edge
	// as the block. It reloads the index only if no word of the current message is in.
	task automatic write_seed(input logic [31:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		hash_seed = value;
		if (!words_taken)
			step_idx = value + HASH_P1;
	endtask

	// Driver: presents the head of the pending queue and holds it until the block takes it.
	// After each transaction it may idle for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid      <= 1'b0;
			msg_ch.data_word  <= '0;
			msg_ch.byte_count <= '0;
			msg_ch.last       <= 1'b0;
			drv_wait = 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				// The model sees exactly what the block sampled at this edge.
				absorb_item(msg_ch.data_word, msg_ch.byte_count, msg_ch.last);
				void'(pending_items.pop_front());
				drv_wait = pick_gap(drv_calm);
			end
			if (msg_ch.valid && !msg_ch.ready) begin
				// A transaction that is offered stays unchanged until it is accepted.
			end else if (drv_wait > 0) begin
				drv_wait--;
				msg_ch.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				msg_ch.valid      <= 1'b1;
				msg_ch.data_word  <= pending_items[0].data_word;
				msg_ch.byte_count <= pending_items[0].byte_count;
				msg_ch.last       <= pending_items[0].last;
			end else begin
				msg_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: drops ready at random, and checks every digest that it takes against the
	// oldest one that the model has queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			stall_wait = 0;
		end else begin
			if (dig_ch.valid && dig_ch.ready) begin
				if (expected_digests.size() == 0) begin
					report_mismatch($sformatf("digest %h arrived with no message completed",
						dig_ch.hash_value));
				end else begin
					mon_want = expected_digests.pop_front();
					if (dig_ch.hash_value !== mon_want.hash_value)
						report_mismatch($sformatf("hash_value %h, expected %h",
							dig_ch.hash_value, mon_want.hash_value));
					if (dig_ch.bad_framing !== mon_want.bad_framing)
						report_mismatch($sformatf("bad_framing %b, expected %b",
							dig_ch.bad_framing, mon_want.bad_framing));
				end
			end
			if (stall_wait > 0) begin
				stall_wait--;
				dig_ch.ready <= 1'b0;
			end else begin
				stall_wait = pick_gap(mon_calm);
				dig_ch.ready <= (stall_wait == 0);
				if (stall_wait > 0)
					stall_wait--;
			end
		end
	end

	// Watchdog: a hung block ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("small_multiply_rotate_hash32_test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int random_items;
		int target;
		int nwords;
		int tail;
		int r;
		int j;
		int phase;
		logic [31:0] seed_value;

		// All inputs are known from time zero, before reset is released.
		arst_n            = 1'b0;
		msg_ch.valid      = 1'b0;
		msg_ch.data_word  = '0;
		msg_ch.byte_count = '0;
		msg_ch.last       = 1'b0;
		dig_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		error_count  = 0;
		cycle_count  = 0;
		queued_count = 0;
		drv_calm     = 1'b0;
		mon_calm     = 1'b0;
		hash_seed    = 32'd0;
		restart_hash();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, first with the seed written to zero.
		write_seed(32'h0000_0000);
		@(negedge clk);
		// An empty message with nothing before it gives the finalized starting hash.
		queue_item(32'hffff_ffff, 3'd0, 1'b1);
		// An empty last transaction after a word raises the framing flag.
		queue_item(32'h0000_0000, 3'd0, 1'b0);
		queue_item(32'h0000_0000, 3'd0, 1'b1);
		// The count on a word transaction is ignored, even at its largest.
		queue_item(32'hffff_ffff, 3'd7, 1'b0);
		queue_item(32'hffff_ffff, 3'd4, 1'b1);
		// Every tail length from one to three bytes.
		queue_item(32'h0000_00ff, 3'd1, 1'b1);
		queue_item(32'h0000_ffff, 3'd2, 1'b1);
		queue_item(32'h00ff_ffff, 3'd3, 1'b1);
		// Oversized tail counts saturate to four.
		queue_item(32'ha5a5_a5a5, 3'd5, 1'b1);
		queue_item(32'h5a5a_5a5a, 3'd6, 1'b1);
		queue_item(32'hffff_ffff, 3'd7, 1'b1);
		queue_item(32'h8000_0000, 3'd0, 1'b0);
		queue_item(32'h0000_0001, 3'd3, 1'b0);
		queue_item(32'h1234_5678, 3'd4, 1'b1);
		// Leave a message open, so that the next seed write must be deferred.
		queue_item(32'h0f0f_0f0f, 3'd2, 1'b0);
		queue_item(32'hf0f0_f0f0, 3'd1, 1'b0);
		wait_drained();
		write_seed(32'hffff_ffff);
		@(negedge clk);
		// Closes the open message with the old index, then one message under the new seed.
		queue_item(32'h0000_abcd, 3'd2, 1'b1);
		queue_item(32'h7fff_ffff, 3'd0, 1'b0);
		queue_item(32'h00c3_3c00, 3'd3, 1'b1);
		wait_drained();
		// Written between messages, so this seed takes effect at once.
		write_seed(32'h0000_0001);
		@(negedge clk);
		queue_item(32'h0000_0000, 3'd4, 1'b1);
		queue_item(32'hffff_ffff, 3'd1, 1'b0);
		queue_item(32'h0000_0000, 3'd1, 1'b1);

		// Random part: phases of mostly well-formed messages, each under its own seed.
		// The first seeds are the extremes, the rest random.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_drained();
			case (phase)
				0:       seed_value = 32'h8000_0000;
				1:       seed_value = 32'hffff_ffff;
				2:       seed_value = 32'h0000_0000;
				default: seed_value = $urandom;
			endcase
			write_seed(seed_value);
			@(negedge clk);
			drv_calm = ($urandom_range(0, 3) == 0);
			mon_calm = ($urandom_range(0, 3) == 0);
			target = $urandom_range(120, 260);
			queued_count = 0;
			while (queued_count < target) begin
				// Message length: mostly short, sometimes a few dozen words.
				r = $urandom_range(0, 99);
				if (r < 10)
					nwords = 0;
				else if (r < 75)
					nwords = $urandom_range(1, 4);
				else if (r < 95)
					nwords = $urandom_range(5, 12);
				else
					nwords = $urandom_range(20, 40);
				for (j = 0; j < nwords; j++)
					queue_item(random_word(), 3'($urandom_range(0, 7)), 1'b0);
				r = $urandom_range(0, 99);
				if (r < 15)
					tail = 0;
				else if (r < 85)
					tail = $urandom_range(1, 4);
				else
					tail = $urandom_range(5, 7);
				queue_item(random_word(), 3'(tail), 1'b1);
			end
			// Sometimes the phase stops mid-message, so the seed write that follows finds
			// words already taken.
			if ($urandom_range(0, 9) < 4) begin
				nwords = $urandom_range(1, 3);
				for (j = 0; j < nwords; j++)
					queue_item(random_word(), 3'($urandom_range(0, 7)), 1'b0);
			end
			random_items += queued_count;
			phase++;
		end

		// Close any open message, then drain with a bound and give the block time to settle.
		@(negedge clk);
		queue_item(random_word(), 3'($urandom_range(0, 4)), 1'b1);
		j = 0;
		while ((pending_items.size() != 0 || msg_ch.valid || expected_digests.size() != 0)
				&& j < DRAIN_LIMIT) begin
			@(posedge clk);
			j++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_digests.size() != 0)
			report_mismatch($sformatf("%0d expected digests never arrived",
				expected_digests.size()));

		if (error_count == 0) begin
			$display("small_multiply_rotate_hash32_test passed");
		end else begin
			$display("small_multiply_rotate_hash32_test failed");
		end
		$finish;
	end

endmodule
